/* rtl/bdfe_pkg.sv */
// ----------------------------------------------------------------------------
// Bus drop frame engine package
// Shared opcodes, result kinds, marker constants and the record types that
// travel between the item engine and the result queue.
// ----------------------------------------------------------------------------
package bdfe_pkg;

    // Marker bits of a received bus word
    localparam logic [31:0] MARK_MASK = 32'hC0C0_C0C0;
    localparam logic [31:0] MARK_VAL  = 32'h0040_80C0;

    // Most results one item can cause
    localparam int MAX_RES = 4;

    // Packet length field width, wide enough for the largest buffer
    localparam int PLEN_W = 13;

    // Result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_A_BYTE   = 3'd0,
        KIND_A_END    = 3'd1,
        KIND_TX_FRAME = 3'd2,
        KIND_B_BYTE   = 3'd3,
        KIND_REALIGN  = 3'd4,
        KIND_STATUS   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data;
        logic [31:0]       frame;
        logic              last;
        logic              accepted;
        logic [PLEN_W-1:0] plen;
    } res_t;

    // Results of one item, pushed into the queue in one cycle
    typedef struct packed {
        logic [MAX_RES-1:0]       vld;
        res_t [MAX_RES-1:0]       res;
        logic                     rtr;
        logic                     cts;
    } push_t;

    typedef struct packed {
        res_t res;
        logic rtr;
        logic cts;
    } entry_t;

endpackage

/* rtl/bus_drop_frame_engine.sv */
// ----------------------------------------------------------------------------
// Bus drop frame engine
// One drop on a shared serial bus: channel A streaming, channel B slot ring,
// outgoing buffer and transmit frame generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one command per transfer: a
//   received bus word, an outgoing byte load, or a channel B byte read.
//   Result channel (m_valid/m_ready) returns zero to four results per
//   command, in order; m_last marks the final result of a word (or the last
//   byte of a B packet for B byte reads).
//   Configuration channel (cfg_valid/cfg_ready) writes drop_id; write it
//   only while no command is in flight.
//   A command is registered, its buffer reads issue in the next cycle and it
//   is applied in the cycle after, when its results enter the result queue.
//   Commands are taken no faster than the read-then-apply sequence on the
//   buffer RAMs and the slot state allows.
//   An eight-entry result queue decouples the receiver; s_ready is low in the
//   cycle after each transfer and while the queue cannot take another
//   command's worth of results.
//   Reset: positions (the channel B read position to 2), flags, credit and
//   slot ring clear, drop_id returns to 1; buffer RAM contents stay as they are.
// ----------------------------------------------------------------------------
module bus_drop_frame_engine #(
    parameter int BUF_BYTES = 256,
    parameter int B_SLOTS   = 4,
    localparam int POS_W    = $clog2(BUF_BYTES + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic [31:0]      s_rx_word,
    input  logic             s_parity_error,
    input  logic [7:0]       s_tx_byte,
    input  logic             s_tx_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_data_byte,
    output logic [31:0]      m_frame_out,
    output logic             m_last,
    output logic             m_accepted,
    output logic [POS_W-1:0] m_packet_length,
    output logic             m_ready_to_receive,
    output logic             m_clear_to_send,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [4:0]       cfg_data
);

    bdfe_pkg::push_t  push;
    bdfe_pkg::entry_t entry;
    logic             room;

    assign cfg_ready = 1'b1;

    // Command engine
    bdfe_core #(
        .BUF_BYTES (BUF_BYTES),
        .B_SLOTS   (B_SLOTS)
    ) u_core (
        .clk            (aclk),
        .rst_n          (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_rx_word      (s_rx_word),
        .s_parity_error (s_parity_error),
        .s_tx_byte      (s_tx_byte),
        .s_tx_last      (s_tx_last),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .room           (room),
        .push           (push)
    );

    // Result queue
    bdfe_fifo u_fifo (
        .clk     (aclk),
        .rst_n   (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_entry (entry)
    );

    // Unpack the head result
    assign m_kind             = entry.res.kind;
    assign m_data_byte        = entry.res.data;
    assign m_frame_out        = entry.res.frame;
    assign m_last             = entry.res.last;
    assign m_accepted         = entry.res.accepted;
    assign m_packet_length    = entry.res.plen[POS_W-1:0];
    assign m_ready_to_receive = entry.rtr;
    assign m_clear_to_send    = entry.cts;

endmodule

/* rtl/bdfe_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bdfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bdfe_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Takes up to four results of one item in one cycle and hands them out one
// transfer at a time on the result channel.
// ----------------------------------------------------------------------------
module bdfe_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  bdfe_pkg::push_t push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output bdfe_pkg::entry_t m_entry
);

    localparam int DEPTH = bdfe_pkg::FIFO_DEPTH;
    localparam int PW    = bdfe_pkg::FIFO_PTR_W;
    localparam int CW    = bdfe_pkg::FIFO_CNT_W;
    localparam int NR    = bdfe_pkg::MAX_RES;

    bdfe_pkg::entry_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] push_n;
    logic [PW-1:0] offs [NR];
    logic          pop;

    // Offset of each pushed result and the push count
    always_comb begin
        logic [CW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NR; i++) begin
            offs[i] = acc[PW-1:0];
            acc     = acc + CW'(push.vld[i]);
        end
        push_n = acc;
    end

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_entry = mem[rd_ptr_reg];
    assign room    = (count_reg + push_n) <= CW'(DEPTH - NR);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n[PW-1:0];
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + push_n - CW'(pop);
    end

    // Hold pointers and count
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge clk) begin
        for (int i = 0; i < NR; i++) begin
            if (push.vld[i]) begin
                mem[wr_ptr_reg + offs[i]] <= '{res: push.res[i], rtr: push.rtr,
                                               cts: push.cts};
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != '0) |-> ((count_reg + push_n) <= CW'(DEPTH)))
        else $error("result queue overflow");

endmodule

/* rtl/bdfe_core.sv */
// ----------------------------------------------------------------------------
// Item engine
// Registers an input item, reads the buffer memories in its read phase and
// applies it to the drop state in the apply phase, producing its results.
// ----------------------------------------------------------------------------
module bdfe_core #(
    parameter int BUF_BYTES = 256,
    parameter int B_SLOTS   = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_opcode,
    input  logic [31:0]     s_rx_word,
    input  logic            s_parity_error,
    input  logic [7:0]      s_tx_byte,
    input  logic            s_tx_last,
    input  logic            cfg_valid,
    input  logic [4:0]      cfg_data,
    input  logic            room,
    output bdfe_pkg::push_t push
);

    localparam int POS_W   = $clog2(BUF_BYTES + 1);
    localparam int SLOT_W  = $clog2(B_SLOTS);
    localparam int HALF    = (BUF_BYTES + 1) / 2;
    localparam int BDEPTH  = B_SLOTS * HALF;
    localparam int BADDR_W = $clog2(BDEPTH);
    localparam int OROWS   = (BUF_BYTES + 2) / 3;
    localparam int OADDR_W = $clog2(OROWS);
    localparam int NR      = bdfe_pkg::MAX_RES;

    // Input register and phase flags
    logic        a_valid_reg, b_valid_reg;
    logic [1:0]  op_reg;
    logic [31:0] word_reg;
    logic        par_reg;
    logic [7:0]  txb_reg;
    logic        txl_reg;
    logic        accept;

    // Drop state
    logic [4:0]        drop_id_reg;
    logic [POS_W-1:0]  a_wpos_reg, a_wpos_next;
    logic              a_fin_reg, a_fin_next;
    logic              a_had_reg, a_had_next;
    logic [B_SLOTS-1:0] b_nz_reg, b_nz_next;
    logic [7:0]        b_f0_reg [B_SLOTS];
    logic [7:0]        b_f0_next [B_SLOTS];
    logic [7:0]        b_f1_reg [B_SLOTS];
    logic [7:0]        b_f1_next [B_SLOTS];
    logic [SLOT_W-1:0] b_head_reg, b_head_next;
    logic [SLOT_W-1:0] b_tail_reg, b_tail_next;
    logic [POS_W-1:0]  b_wpos_reg, b_wpos_next;
    logic              b_had_reg, b_had_next;
    logic [POS_W-1:0]  b_rpos_reg, b_rpos_next;
    logic [POS_W-1:0]  o_rpos_reg, o_rpos_next;
    logic [OADDR_W-1:0] o_row_reg, o_row_next;
    logic [POS_W-1:0]  o_len_reg, o_len_next;
    logic [POS_W-1:0]  ld_pos_reg, ld_pos_next;
    logic [1:0]        ld_bank_reg, ld_bank_next;
    logic [OADDR_W-1:0] ld_row_reg, ld_row_next;
    logic [7:0]        credit_reg, credit_next;

    // Memory ports
    logic               bw_we [2];
    logic [BADDR_W-1:0] bw_addr [2];
    logic [7:0]         bw_data [2];
    logic [7:0]         b_rd [2];
    logic [BADDR_W-1:0] b_raddr;
    logic               len_we;
    logic [SLOT_W-1:0]  len_waddr;
    logic [POS_W-1:0]   len_wdata;
    logic [POS_W-1:0]   len_rd;
    logic               ow_we [3];
    logic [7:0]         o_rd [3];

    bdfe_pkg::push_t push_next;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(B_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic rtr_of(input logic [B_SLOTS-1:0] nz,
                                    input logic [SLOT_W-1:0] head);
        return !nz[head] && !nz[slot_inc(head)];
    endfunction

    function automatic logic [BADDR_W-1:0] b_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [POS_W-1:0] pos);
        logic [BADDR_W+POS_W-1:0] full;
        full = (BADDR_W + POS_W)'(slot) * (BADDR_W + POS_W)'(HALF)
             + (BADDR_W + POS_W)'(pos >> 1);
        return full[BADDR_W-1:0];
    endfunction

    assign s_ready = !a_valid_reg && room;
    assign accept  = s_valid && s_ready;

    // Read addresses follow the committed state
    assign b_raddr = b_addr(b_tail_reg, b_rpos_reg);

    for (genvar g = 0; g < 2; g++) begin : g_bbank
        bdfe_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_bram (
            .clk   (clk),
            .we    (bw_we[g]),
            .waddr (bw_addr[g]),
            .wdata (bw_data[g]),
            .raddr (b_raddr),
            .rdata (b_rd[g])
        );
    end

    for (genvar g = 0; g < 3; g++) begin : g_obank
        bdfe_ram #(.WIDTH(8), .DEPTH(OROWS)) u_oram (
            .clk   (clk),
            .we    (ow_we[g]),
            .waddr (ld_row_reg),
            .wdata (txb_reg),
            .raddr (o_row_reg),
            .rdata (o_rd[g])
        );
    end

    bdfe_ram #(.WIDTH(POS_W), .DEPTH(B_SLOTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (b_tail_reg),
        .rdata (len_rd)
    );

    // Apply the item held in the apply phase
    always_comb begin
        logic [1:0]       tok;
        logic             ch;
        logic [4:0]       tap;
        logic [7:0]       hb0, hb1;
        logic [7:0]       f0, f1, v;
        logic [POS_W-1:0] wp, rp1, blen, rem, aw;
        logic [1:0]       num;
        logic [7:0]       fb [3];
        logic [31:0]      frame;
        logic             any_later;

        tok = (word_reg[29:28] == 2'd3) ? 2'd2 : word_reg[29:28];
        ch  = word_reg[27];
        tap = word_reg[26:24] == 3'd0 ? {3'd0, word_reg[21:20]}
                                      : {word_reg[26:24], word_reg[21:20]};
        hb0 = {word_reg[19:16], word_reg[13:10]};
        hb1 = {word_reg[9:8], word_reg[5:0]};

        a_wpos_next  = a_wpos_reg;
        a_fin_next   = a_fin_reg;
        a_had_next   = a_had_reg;
        b_nz_next    = b_nz_reg;
        b_f0_next    = b_f0_reg;
        b_f1_next    = b_f1_reg;
        b_head_next  = b_head_reg;
        b_tail_next  = b_tail_reg;
        b_wpos_next  = b_wpos_reg;
        b_had_next   = b_had_reg;
        b_rpos_next  = b_rpos_reg;
        o_rpos_next  = o_rpos_reg;
        o_row_next   = o_row_reg;
        o_len_next   = o_len_reg;
        ld_pos_next  = ld_pos_reg;
        ld_bank_next = ld_bank_reg;
        ld_row_next  = ld_row_reg;
        credit_next  = credit_reg;

        for (int i = 0; i < 2; i++) begin
            bw_we[i]   = 1'b0;
            bw_addr[i] = '0;
            bw_data[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            ow_we[i] = 1'b0;
        end
        len_we    = 1'b0;
        len_waddr = b_head_reg;
        len_wdata = '0;

        push_next = '0;
        wp = '0; rp1 = '0; blen = '0; rem = '0; aw = '0; num = '0;
        f0 = '0; f1 = '0; v = '0; frame = '0; any_later = 1'b0;
        for (int i = 0; i < 3; i++) begin
            fb[i] = '0;
        end

        if (b_valid_reg) begin
            case (bdfe_pkg::op_t'(op_reg))
                bdfe_pkg::OP_RX: begin
                    if (!par_reg) begin
                        if ((word_reg & bdfe_pkg::MARK_MASK) != bdfe_pkg::MARK_VAL) begin
                            // Flag realignment, change nothing
                            push_next.vld[0]      = 1'b1;
                            push_next.res[0].kind = bdfe_pkg::KIND_REALIGN;
                        end else begin
                            if (!ch) begin
                                // Stream channel A bytes
                                aw = a_wpos_reg;
                                if (tok != 2'd0 && a_fin_reg) begin
                                    a_fin_next = 1'b0;
                                    aw         = '0;
                                end
                                if (tok != 2'd0 && aw < POS_W'(BUF_BYTES)) begin
                                    aw                    = aw + 1'b1;
                                    push_next.vld[0]      = 1'b1;
                                    push_next.res[0].kind = bdfe_pkg::KIND_A_BYTE;
                                    push_next.res[0].data = hb0;
                                end
                                if (tok == 2'd2 && aw < POS_W'(BUF_BYTES)) begin
                                    aw                    = aw + 1'b1;
                                    push_next.vld[1]      = 1'b1;
                                    push_next.res[1].kind = bdfe_pkg::KIND_A_BYTE;
                                    push_next.res[1].data = hb1;
                                end
                                if (tok == 2'd2) begin
                                    a_had_next = 1'b1;
                                end else if (tok == 2'd1 || a_had_reg) begin
                                    a_had_next            = 1'b0;
                                    a_fin_next            = 1'b1;
                                    push_next.vld[2]      = 1'b1;
                                    push_next.res[2].kind = bdfe_pkg::KIND_A_END;
                                    push_next.res[2].plen = bdfe_pkg::PLEN_W'(aw);
                                end
                                a_wpos_next = aw;
                            end else begin
                                // Fill the head slot with channel B bytes
                                wp = b_wpos_reg;
                                if (tok != 2'd0 && b_nz_reg[b_head_reg]) begin
                                    b_nz_next[b_head_reg] = 1'b0;
                                    wp                    = '0;
                                end
                                f0 = b_f0_reg[b_head_reg];
                                f1 = b_f1_reg[b_head_reg];
                                if (tok != 2'd0 && wp < POS_W'(BUF_BYTES)) begin
                                    bw_we[wp[0]]   = 1'b1;
                                    bw_addr[wp[0]] = b_addr(b_head_reg, wp);
                                    bw_data[wp[0]] = hb0;
                                    if (wp == POS_W'(0)) f0 = hb0;
                                    if (wp == POS_W'(1)) f1 = hb0;
                                    wp = wp + 1'b1;
                                end
                                if (tok == 2'd2 && wp < POS_W'(BUF_BYTES)) begin
                                    bw_we[wp[0]]   = 1'b1;
                                    bw_addr[wp[0]] = b_addr(b_head_reg, wp);
                                    bw_data[wp[0]] = hb1;
                                    if (wp == POS_W'(0)) f0 = hb1;
                                    if (wp == POS_W'(1)) f1 = hb1;
                                    wp = wp + 1'b1;
                                end
                                b_f0_next[b_head_reg] = f0;
                                b_f1_next[b_head_reg] = f1;
                                b_wpos_next           = wp;
                                if (tok == 2'd2) begin
                                    b_had_next = 1'b1;
                                end else if (tok == 2'd1 || b_had_reg) begin
                                    b_had_next = 1'b0;
                                    if (f0 == {3'd0, drop_id_reg}) begin
                                        // Commit the packet and take its credit
                                        credit_next           = f1;
                                        len_we                = 1'b1;
                                        len_wdata             = wp;
                                        b_nz_next[b_head_reg] = (wp != '0);
                                        b_head_next           = slot_inc(b_head_reg);
                                    end
                                    b_wpos_next = '0;
                                end
                            end

                            // Build the transmit frame in our slot
                            if (tap == drop_id_reg) begin
                                if (tok != 2'd2) begin
                                    credit_next = hb1;
                                end
                                if (o_len_reg != '0) begin
                                    rem = (o_len_reg > o_rpos_reg) ? o_len_reg - o_rpos_reg
                                                                   : '0;
                                    num = (rem > POS_W'(3)) ? 2'd3 : rem[1:0];
                                    for (int k = 0; k < 3; k++) begin
                                        fb[k] = (2'(k) < num) ? o_rd[k] : 8'd0;
                                    end
                                    frame = {num, 1'b0, drop_id_reg, fb[0], fb[1], 8'd0};
                                    if (num != 2'd3) begin
                                        frame[0]    = rtr_of(b_nz_next, b_head_next);
                                        o_len_next  = '0;
                                        o_rpos_next = '0;
                                        o_row_next  = '0;
                                    end else begin
                                        frame[7:0]  = fb[2];
                                        o_rpos_next = o_rpos_reg + POS_W'(3);
                                        o_row_next  = o_row_reg + 1'b1;
                                    end
                                end else begin
                                    frame = {3'd0, drop_id_reg, 23'd0,
                                             rtr_of(b_nz_next, b_head_next)};
                                end
                                push_next.vld[3]       = 1'b1;
                                push_next.res[3].kind  = bdfe_pkg::KIND_TX_FRAME;
                                push_next.res[3].frame = frame;
                            end
                        end

                        // Mark the final result of the word
                        any_later = 1'b0;
                        for (int i = NR - 1; i >= 0; i--) begin
                            push_next.res[i].last = push_next.vld[i] && !any_later;
                            any_later             = any_later || push_next.vld[i];
                        end
                    end
                end

                bdfe_pkg::OP_LOAD: begin
                    push_next.vld[0]      = 1'b1;
                    push_next.res[0].kind = bdfe_pkg::KIND_STATUS;
                    push_next.res[0].last = 1'b1;
                    if (o_len_reg == '0 && credit_reg != 8'd0) begin
                        aw = ld_pos_reg;
                        if (aw < POS_W'(BUF_BYTES)) begin
                            // Store the byte in its bank and advance
                            ow_we[ld_bank_reg]        = 1'b1;
                            aw                        = aw + 1'b1;
                            push_next.res[0].accepted = 1'b1;
                            if (ld_bank_reg == 2'd2) begin
                                ld_bank_next = 2'd0;
                                ld_row_next  = ld_row_reg + 1'b1;
                            end else begin
                                ld_bank_next = ld_bank_reg + 1'b1;
                            end
                        end
                        ld_pos_next = aw;
                        if (txl_reg) begin
                            credit_next  = credit_reg - 8'd1;
                            o_len_next   = aw;
                            o_rpos_next  = '0;
                            o_row_next   = '0;
                            ld_pos_next  = '0;
                            ld_bank_next = '0;
                            ld_row_next  = '0;
                        end
                    end
                end

                bdfe_pkg::OP_READ: begin
                    push_next.vld[0]      = 1'b1;
                    push_next.res[0].kind = bdfe_pkg::KIND_STATUS;
                    push_next.res[0].last = 1'b1;
                    if (b_head_reg != b_tail_reg) begin
                        blen = b_nz_reg[b_tail_reg] ? len_rd : '0;
                        if (b_rpos_reg >= blen || b_rpos_reg >= POS_W'(BUF_BYTES)) begin
                            // Drop a packet without payload
                            b_nz_next[b_tail_reg]     = 1'b0;
                            b_tail_next               = slot_inc(b_tail_reg);
                            b_rpos_next               = POS_W'(2);
                            push_next.res[0].accepted = 1'b1;
                        end else begin
                            v                     = b_rd[b_rpos_reg[0]];
                            rp1                   = b_rpos_reg + 1'b1;
                            push_next.res[0].kind = bdfe_pkg::KIND_B_BYTE;
                            push_next.res[0].data = v;
                            if (rp1 >= blen) begin
                                b_nz_next[b_tail_reg] = 1'b0;
                                b_tail_next           = slot_inc(b_tail_reg);
                                b_rpos_next           = POS_W'(2);
                            end else begin
                                push_next.res[0].last = 1'b0;
                                b_rpos_next           = rp1;
                            end
                        end
                    end
                end

                default: begin
                    push_next.vld[0]      = 1'b1;
                    push_next.res[0].kind = bdfe_pkg::KIND_STATUS;
                    push_next.res[0].last = 1'b1;
                end
            endcase
        end

        push_next.rtr = rtr_of(b_nz_next, b_head_next);
        push_next.cts = (o_len_next == '0) && (credit_next != 8'd0);
    end

    assign push = push_next;

    // Capture the accepted item
    always_ff @(posedge clk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            word_reg <= s_rx_word;
            par_reg  <= s_parity_error;
            txb_reg  <= s_tx_byte;
            txl_reg  <= s_tx_last;
        end
    end

    // Hold phase flags, configuration and drop state
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            drop_id_reg <= 5'd1;
            a_wpos_reg  <= '0;
            a_fin_reg   <= 1'b0;
            a_had_reg   <= 1'b0;
            b_nz_reg    <= '0;
            for (int i = 0; i < B_SLOTS; i++) begin
                b_f0_reg[i] <= '0;
                b_f1_reg[i] <= '0;
            end
            b_head_reg  <= '0;
            b_tail_reg  <= '0;
            b_wpos_reg  <= '0;
            b_had_reg   <= 1'b0;
            b_rpos_reg  <= POS_W'(2);
            o_rpos_reg  <= '0;
            o_row_reg   <= '0;
            o_len_reg   <= '0;
            ld_pos_reg  <= '0;
            ld_bank_reg <= '0;
            ld_row_reg  <= '0;
            credit_reg  <= '0;
        end else begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (cfg_valid) begin
                drop_id_reg <= cfg_data;
            end
            a_wpos_reg  <= a_wpos_next;
            a_fin_reg   <= a_fin_next;
            a_had_reg   <= a_had_next;
            b_nz_reg    <= b_nz_next;
            b_f0_reg    <= b_f0_next;
            b_f1_reg    <= b_f1_next;
            b_head_reg  <= b_head_next;
            b_tail_reg  <= b_tail_next;
            b_wpos_reg  <= b_wpos_next;
            b_had_reg   <= b_had_next;
            b_rpos_reg  <= b_rpos_next;
            o_rpos_reg  <= o_rpos_next;
            o_row_reg   <= o_row_next;
            o_len_reg   <= o_len_next;
            ld_pos_reg  <= ld_pos_next;
            ld_bank_reg <= ld_bank_next;
            ld_row_reg  <= ld_row_next;
            credit_reg  <= credit_next;
        end
    end

    a_read_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |=> b_valid_reg)
        else $error("read cycle not followed by apply cycle");

    a_apply_single: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |=> !b_valid_reg)
        else $error("apply cycles back to back");

    a_push_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (push_next.vld != '0) |-> b_valid_reg)
        else $error("results pushed outside apply cycle");

endmodule

/* dv/bus_drop_frame_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bus drop frame engine testbench
// Drives commands into the engine with bursty valid and a stalling receiver.
// It predicts every result with its own model of the drop state, checks each
// result transfer in order and sweeps drop_id over several settings.
// ----------------------------------------------------------------------------
module bus_drop_frame_engine_test;

    typedef struct packed {
        bdfe_pkg::kind_t kind;
        logic [7:0]      data;
        logic [31:0]     frame;
        logic            last;
        logic            acc;
        logic [8:0]      plen;
        logic            rtr;
        logic            cts;
    } drop_res_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
        logic        perr;
        logic [7:0]  tbyte;
        logic        tlast;
    } cmd_t;

    // Holds expected results in order and checks each received one
    class drop_scoreboard;
        drop_res_t pending[$];
        int        errors;
        int        checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function void note_item(drop_res_t res[$]);
            foreach (res[i]) pending.push_back(res[i]);
        endfunction

        function void check_result(drop_res_t got);
            drop_res_t want;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: kind %0d frame %h", $time,
                         got.kind, got.frame);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected kind %0d data %h frame %h last %b acc %b",
                         $time, want.kind, want.data, want.frame, want.last, want.acc);
                $display("    plen %0d rtr %b cts %b", want.plen, want.rtr, want.cts);
                $display("    actual   kind %0d data %h frame %h last %b acc %b",
                         got.kind, got.data, got.frame, got.last, got.acc);
                $display("    plen %0d rtr %b cts %b", got.plen, got.rtr, got.cts);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [31:0] s_rx_word = '0;
    logic        s_parity_error = 1'b0;
    logic [7:0]  s_tx_byte = '0;
    logic        s_tx_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [31:0] m_frame_out;
    logic        m_last;
    logic        m_accepted;
    logic [8:0]  m_packet_length;
    logic        m_ready_to_receive;
    logic        m_clear_to_send;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd1;

    always #1 aclk = ~aclk;

    bus_drop_frame_engine dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_rx_word         (s_rx_word),
        .s_parity_error    (s_parity_error),
        .s_tx_byte         (s_tx_byte),
        .s_tx_last         (s_tx_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_data_byte       (m_data_byte),
        .m_frame_out       (m_frame_out),
        .m_last            (m_last),
        .m_accepted        (m_accepted),
        .m_packet_length   (m_packet_length),
        .m_ready_to_receive(m_ready_to_receive),
        .m_clear_to_send   (m_clear_to_send),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    drop_scoreboard sb = new();
    cmd_t           stim[$];
    bit             hold_req = 1'b0;
    int             items_sent = 0;
    int             idle_cycles = 0;

    // ------------------------------------------------------------------
    // Drop state as seen by the predictor
    // ------------------------------------------------------------------
    logic [4:0]  my_id = 5'd1;
    int unsigned a_wpos = 0, b_wpos = 0, b_rpos = 2;
    bit          a_fin = 0, a_tok = 0, b_tok = 0;
    logic [7:0]  b_mem [1024];
    logic [7:0]  o_mem [256];
    int unsigned slot_len [4] = '{0, 0, 0, 0};
    int unsigned b_hd = 0, b_tl = 0;
    int unsigned o_rpos = 0, o_len = 0, ld_pos = 0;
    logic [7:0]  credit = 8'd0;
    drop_res_t   item_res[$];

    function automatic bit ring_free();
        return slot_len[b_hd] == 0 && slot_len[(b_hd + 1) % 4] == 0;
    endfunction

    function automatic bit send_ok();
        return o_len == 0 && credit != 0;
    endfunction

    function automatic void add_res(bdfe_pkg::kind_t k, logic [7:0] d, logic [31:0] f,
                                    logic l, logic a, logic [8:0] p);
        drop_res_t r;
        r = '{kind: k, data: d, frame: f, last: l, acc: a, plen: p, rtr: 1'b0, cts: 1'b0};
        item_res.push_back(r);
    endfunction

    function automatic logic [7:0] out_byte(int unsigned p, int unsigned num, int unsigned k);
        return (k < num && p + k < 256) ? o_mem[p + k] : 8'd0;
    endfunction

    // Apply one received bus word
    function automatic void apply_word(logic [31:0] w);
        logic [7:0]  hdr, byt[2];
        int unsigned tok, base, num, rp;
        logic [31:0] frame;
        if ((w & bdfe_pkg::MARK_MASK) != bdfe_pkg::MARK_VAL) begin
            add_res(bdfe_pkg::KIND_REALIGN, 8'd0, 32'd0, 1'b1, 1'b0, 9'd0);
            return;
        end
        hdr = {w[29:24], w[21:20]};
        byt[0] = {w[19:16], w[13:10]};
        byt[1] = {w[9:8], w[5:0]};
        tok = hdr[7:6];
        if (tok > 2) tok = 2;
        if (!hdr[5]) begin
            if (tok > 0 && a_fin) begin
                a_fin = 0;
                a_wpos = 0;
            end
            for (int i = 0; i < tok; i++) begin
                if (a_wpos < 256) begin
                    a_wpos++;
                    add_res(bdfe_pkg::KIND_A_BYTE, byt[i], 32'd0, 1'b0, 1'b0, 9'd0);
                end
            end
            if (tok == 2) a_tok = 1;
            else if (tok == 1 || a_tok) begin
                a_tok = 0;
                a_fin = 1;
                add_res(bdfe_pkg::KIND_A_END, 8'd0, 32'd0, 1'b0, 1'b0, 9'(a_wpos));
            end
        end else begin
            base = b_hd * 256;
            if (tok > 0 && slot_len[b_hd] != 0) begin
                slot_len[b_hd] = 0;
                b_wpos = 0;
            end
            for (int i = 0; i < tok; i++) begin
                if (b_wpos < 256) begin
                    b_mem[base + b_wpos] = byt[i];
                    b_wpos++;
                end
            end
            if (tok == 2) b_tok = 1;
            else if (tok == 1 || b_tok) begin
                b_tok = 0;
                if (b_mem[base] == {3'd0, my_id}) begin
                    credit = b_mem[base + 1];
                    slot_len[b_hd] = b_wpos;
                    b_hd = (b_hd + 1) % 4;
                end
                b_wpos = 0;
            end
        end
        // Build the transmit frame in our slot
        if (hdr[4:0] == my_id) begin
            if (tok < 2) credit = byt[1];
            if (o_len > 0) begin
                rp = o_rpos;
                num = o_len > rp ? o_len - rp : 0;
                if (num > 3) num = 3;
                frame = {num[1:0], 1'b0, my_id, out_byte(rp, num, 0), out_byte(rp, num, 1),
                         8'd0};
                if (num < 3) begin
                    frame[0] = ring_free();
                    o_len = 0;
                    o_rpos = 0;
                end else begin
                    frame[7:0] = out_byte(rp, num, 2);
                    o_rpos = rp + 3;
                end
            end else begin
                frame = {3'd0, my_id, 23'd0, ring_free()};
            end
            add_res(bdfe_pkg::KIND_TX_FRAME, 8'd0, frame, 1'b0, 1'b0, 9'd0);
        end
        if (item_res.size() > 0) item_res[item_res.size() - 1].last = 1'b1;
    endfunction

    // Load one outgoing byte under credit
    function automatic void apply_load(logic [7:0] b, logic lb);
        logic acc;
        acc = 1'b0;
        if (!send_ok()) begin
            add_res(bdfe_pkg::KIND_STATUS, 8'd0, 32'd0, 1'b1, 1'b0, 9'd0);
            return;
        end
        if (ld_pos < 256) begin
            o_mem[ld_pos] = b;
            ld_pos++;
            acc = 1'b1;
        end
        if (lb) begin
            credit = credit - 8'd1;
            o_len = ld_pos;
            o_rpos = 0;
            ld_pos = 0;
        end
        add_res(bdfe_pkg::KIND_STATUS, 8'd0, 32'd0, 1'b1, acc, 9'd0);
    endfunction

    // Pop one channel B byte
    function automatic void apply_read();
        int unsigned len;
        logic [7:0]  v;
        if (b_hd == b_tl) begin
            add_res(bdfe_pkg::KIND_STATUS, 8'd0, 32'd0, 1'b1, 1'b0, 9'd0);
            return;
        end
        len = slot_len[b_tl];
        if (b_rpos >= len || b_rpos >= 256) begin
            slot_len[b_tl] = 0;
            b_tl = (b_tl + 1) % 4;
            b_rpos = 2;
            add_res(bdfe_pkg::KIND_STATUS, 8'd0, 32'd0, 1'b1, 1'b1, 9'd0);
            return;
        end
        v = b_mem[b_tl * 256 + b_rpos];
        b_rpos++;
        if (b_rpos >= len) begin
            slot_len[b_tl] = 0;
            b_tl = (b_tl + 1) % 4;
            b_rpos = 2;
            add_res(bdfe_pkg::KIND_B_BYTE, v, 32'd0, 1'b1, 1'b0, 9'd0);
        end else begin
            add_res(bdfe_pkg::KIND_B_BYTE, v, 32'd0, 1'b0, 1'b0, 9'd0);
        end
    endfunction

    function automatic void predict_item(cmd_t c);
        item_res.delete();
        case (c.op)
            bdfe_pkg::OP_RX:   if (!c.perr) apply_word(c.word);
            bdfe_pkg::OP_LOAD: apply_load(c.tbyte, c.tlast);
            bdfe_pkg::OP_READ: apply_read();
            default: add_res(bdfe_pkg::KIND_STATUS, 8'd0, 32'd0, 1'b1, 1'b0, 9'd0);
        endcase
        foreach (item_res[i]) begin
            item_res[i].rtr = ring_free();
            item_res[i].cts = send_ok();
        end
        sb.note_item(item_res);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic logic [31:0] bus_word(logic [1:0] tok, logic ch, logic [4:0] tap,
                                             logic [7:0] b0, logic [7:0] b1);
        logic [7:0] hdr;
        hdr = {tok, ch, tap};
        return {2'b00, hdr[7:2], 2'b01, hdr[1:0], b0[7:4], 2'b10, b0[3:0],
                b1[7:6], 2'b11, b1[5:0]};
    endfunction

    function automatic void push_word(logic [31:0] w, logic perr);
        stim.push_back('{op: bdfe_pkg::OP_RX, word: w, perr: perr, tbyte: 8'($urandom),
                         tlast: 1'($urandom)});
    endfunction

    function automatic void push_rx(logic [1:0] tok, logic ch, logic [4:0] tap,
                                    logic [7:0] b0, logic [7:0] b1);
        push_word(bus_word(tok, ch, tap, b0, b1), 1'b0);
    endfunction

    function automatic void push_cmd(logic [1:0] op, logic [7:0] b, logic lb);
        stim.push_back('{op: op, word: $urandom, perr: 1'($urandom), tbyte: b, tlast: lb});
    endfunction

    function automatic logic [4:0] pick_tap();
        return ($urandom_range(0, 3) == 0) ? my_id : 5'($urandom);
    endfunction

    // Well-formed packets, loads and reads, with some noise mixed in
    function automatic void build_random(int count);
        int target, r, m;
        logic ch;
        target = stim.size() + count;
        while (stim.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                ch = 1'($urandom);
                m = $urandom_range(0, 4);
                for (int i = 0; i < m; i++)
                    push_rx(2'd2 + 2'($urandom_range(0, 1)), ch, pick_tap(),
                            (i == 0 && ch && $urandom_range(0, 9) < 7) ? {3'd0, my_id}
                                                                      : 8'($urandom),
                            8'($urandom));
                push_rx(2'($urandom_range(0, 1)), ch, pick_tap(),
                        (m == 0 && ch) ? {3'd0, my_id} : 8'($urandom), 8'($urandom));
            end else if (r < 55) begin
                m = $urandom_range(1, 5);
                for (int i = 0; i < m; i++)
                    push_cmd(bdfe_pkg::OP_LOAD, 8'($urandom), i == m - 1);
            end else if (r < 70) begin
                m = $urandom_range(1, 4);
                for (int i = 0; i < m; i++)
                    push_cmd(bdfe_pkg::OP_READ, 8'($urandom), 1'($urandom));
            end else if (r < 82) begin
                push_rx(2'($urandom), 1'($urandom), my_id, 8'($urandom), 8'($urandom));
            end else if (r < 90) begin
                push_word($urandom, 1'b0);
            end else begin
                stim.push_back('{op: 2'($urandom), word: $urandom, perr: 1'($urandom),
                                 tbyte: 8'($urandom), tlast: 1'($urandom)});
            end
        end
    endfunction

    // Overfill the outgoing buffer, then overfill channel A while our slot drains it
    function automatic void build_overflow();
        push_rx(2'd0, 1'b0, my_id, 8'd0, 8'd200);
        for (int i = 0; i < 257; i++)
            push_cmd(bdfe_pkg::OP_LOAD, 8'($urandom), i == 256);
        for (int i = 0; i < 129; i++)
            push_rx(2'd2, 1'b0, my_id, 8'($urandom), 8'($urandom));
        push_rx(2'd0, 1'b0, 5'd0, 8'd0, 8'd0);
    endfunction

    function automatic void build_directed();
        // Commit and drain one short packet per slot so each slot head is written
        for (int s = 0; s < 4; s++) begin
            push_rx(2'd2, 1'b1, 5'd0, {3'd0, my_id}, 8'd5);
            push_rx(2'd0, 1'b1, 5'd0, 8'd0, 8'd0);
            push_cmd(bdfe_pkg::OP_READ, 8'd0, 1'b0);
        end
        push_rx(2'd1, 1'b0, 5'd0, 8'hFF, 8'h00);
        push_rx(2'd2, 1'b0, 5'd31, 8'h00, 8'hFF);
        push_rx(2'd3, 1'b0, 5'd0, 8'hA5, 8'h5A);
        push_rx(2'd0, 1'b0, 5'd0, 8'd0, 8'd0);
        push_word(bus_word(2'd1, 1'b0, 5'd0, 8'h12, 8'h34), 1'b1);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_cmd(2'd3, 8'hFF, 1'b1);
        push_cmd(bdfe_pkg::OP_READ, 8'd0, 1'b0);
        push_cmd(bdfe_pkg::OP_LOAD, 8'hFF, 1'b0);
        push_cmd(bdfe_pkg::OP_LOAD, 8'h00, 1'b1);
        push_cmd(bdfe_pkg::OP_LOAD, 8'h77, 1'b1);
        push_rx(2'd0, 1'b0, my_id, 8'd0, 8'd0);
        push_rx(2'd1, 1'b1, 5'd0, {3'd0, my_id}, 8'd0);
        push_cmd(bdfe_pkg::OP_READ, 8'd0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_items();
        int burst;
        burst = $urandom_range(1, 20);
        while (stim.size() > 0) begin
            cmd_t c;
            c = stim.pop_front();
            if (burst == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst = $urandom_range(1, 20);
            end
            burst--;
            s_valid        <= 1'b1;
            s_opcode       <= c.op;
            s_rx_word      <= c.word;
            s_parity_error <= c.perr;
            s_tx_byte      <= c.tbyte;
            s_tx_last      <= c.tlast;
            do @(posedge aclk); while (!s_ready);
            items_sent++;
        end
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_drop_id(logic [4:0] id);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        my_id = id;
    endtask

    // Receiver: stall on a rotating pattern, or hold off for a long stretch
    initial begin
        int unsigned pat;
        pat = $urandom;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end
            pat = {pat[30:0], pat[31]};
            if ($urandom_range(0, 63) == 0) pat = $urandom;
            m_ready <= pat[0] | pat[3];
        end
    end

    // Predict on input transfers, check on result transfers, watch for hangs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_item('{op: s_opcode, word: s_rx_word, perr: s_parity_error,
                               tbyte: s_tx_byte, tlast: s_tx_last});
            if (m_valid && m_ready)
                sb.check_result('{kind: bdfe_pkg::kind_t'(m_kind), data: m_data_byte,
                                  frame: m_frame_out, last: m_last, acc: m_accepted,
                                  plen: m_packet_length, rtr: m_ready_to_receive,
                                  cts: m_clear_to_send});
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("%0t: watchdog expired, %0d results pending", $time,
                         sb.pending.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_directed();
        send_items();
        wait_idle();

        write_drop_id(5'd31);
        build_overflow();
        send_items();
        wait_idle();

        write_drop_id(5'($urandom_range(2, 30)));
        hold_req = 1'b1;
        build_random(40);
        send_items();
        wait_idle();

        write_drop_id(5'd1);
        build_random(40);
        send_items();
        wait_idle();

        $display("covered %0d commands, %0d results checked, drop_id 31/random/1,",
                 items_sent, sb.checked);
        $display("outgoing and channel A buffers overfilled, long receiver hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d errors, %0d results never arrived", sb.errors, sb.pending.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
